// ===== rtl/pt2_pkg.sv =====
package pt2_pkg;

   // field widths
   localparam int OP_W      = 3;
   localparam int COORD_W   = 24;
   localparam int ANGLE_W   = 17;
   localparam int FACTOR_W  = 16;

   // fixed-point setup
   localparam int FRAC_BITS     = 8;
   localparam int CORDIC_STAGES = 16;
   localparam int IDX_W         = $clog2(CORDIC_STAGES);
   localparam int TRIG_FRAC     = 30;
   localparam int ATAN_LEN      = 24;

   // internal widths
   localparam int PRE_W   = COORD_W + 2;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int XY_W    = TRIG_FRAC + 3;
   localparam int Z_W     = 30;
   localparam int ANG_W   = ANGLE_W + 1;
   localparam int PROD_W  = DIFF_W + XY_W;
   localparam int SPROD_W = DIFF_W + FACTOR_W;
   localparam int WIDE_W  = PROD_W + 2;

   // pipeline depth: prep, cordic cells, products, output
   localparam int PIPE_DEPTH = CORDIC_STAGES + 3;
   localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

   // angle units: 1/128 degree
   localparam logic signed [ANG_W-1:0] TURN         = 18'sd46080;
   localparam logic signed [ANG_W-1:0] HALF_TURN    = 18'sd23040;
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = 18'sd11520;
   localparam logic signed [ANG_W-1:0] NEG_HALF     = -18'sd23040;
   localparam logic signed [ANG_W-1:0] NEG_QUARTER  = -18'sd11520;
   localparam int Z_SHIFT = 13;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

   localparam logic signed [WIDE_W-1:0] COORD_MAX = WIDE_W'(64'sd8388607);
   localparam logic signed [WIDE_W-1:0] COORD_MIN = -WIDE_W'(64'sd8388608);

   // operation codes
   localparam logic [OP_W-1:0] OP_TRANSLATE = 3'd0;
   localparam logic [OP_W-1:0] OP_SCALE     = 3'd1;
   localparam logic [OP_W-1:0] OP_ROTATE    = 3'd2;
   localparam logic [OP_W-1:0] OP_MIRROR_X  = 3'd3;
   localparam logic [OP_W-1:0] OP_MIRROR_Y  = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]                req_type;
      logic signed [COORD_W-1:0]      px;
      logic signed [COORD_W-1:0]      py;
      logic signed [COORD_W-1:0]      cx;
      logic signed [COORD_W-1:0]      cy;
      logic signed [ANGLE_W-1:0]      angle_deg;
      logic signed [FACTOR_W-1:0]     factor;
      logic signed [COORD_W-1:0]      dx;
      logic signed [COORD_W-1:0]      dy;
   } req_item_type;

   typedef struct packed {
      logic [OP_W-1:0]                op;
      logic                           neg;
      logic signed [PRE_W-1:0]        pre_x;
      logic signed [PRE_W-1:0]        pre_y;
      logic signed [COORD_W-1:0]      cx;
      logic signed [COORD_W-1:0]      cy;
      logic signed [DIFF_W-1:0]       u;
      logic signed [DIFF_W-1:0]       v;
      logic signed [FACTOR_W-1:0]     factor;
      logic signed [XY_W-1:0]         x;
      logic signed [XY_W-1:0]         y;
      logic signed [Z_W-1:0]          z;
   } cord_type;

   typedef struct packed {
      logic [OP_W-1:0]                op;
      logic                           neg;
      logic signed [PRE_W-1:0]        pre_x;
      logic signed [PRE_W-1:0]        pre_y;
      logic signed [COORD_W-1:0]      cx;
      logic signed [COORD_W-1:0]      cy;
      logic signed [PROD_W-1:0]       ux;
      logic signed [PROD_W-1:0]       vy;
      logic signed [PROD_W-1:0]       uy;
      logic signed [PROD_W-1:0]       vx;
      logic signed [SPROD_W-1:0]      us;
      logic signed [SPROD_W-1:0]      vs;
   } prod_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]      rx;
      logic signed [COORD_W-1:0]      ry;
      logic                           clipped;
   } res_type;

   // rounded arctangent of 2^-i, 2^20 units per degree
   function automatic logic signed [Z_W-1:0] arctan_of(input logic [IDX_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      case (int'(idx))
         0:       val = 30'sd47185920;
         1:       val = 30'sd27855475;
         2:       val = 30'sd14718068;
         3:       val = 30'sd7471121;
         4:       val = 30'sd3750058;
         5:       val = 30'sd1876857;
         6:       val = 30'sd938658;
         7:       val = 30'sd469357;
         8:       val = 30'sd234682;
         9:       val = 30'sd117342;
         10:      val = 30'sd58671;
         11:      val = 30'sd29335;
         12:      val = 30'sd14668;
         13:      val = 30'sd7334;
         14:      val = 30'sd3667;
         15:      val = 30'sd1833;
         16:      val = 30'sd917;
         17:      val = 30'sd458;
         18:      val = 30'sd229;
         19:      val = 30'sd115;
         20:      val = 30'sd57;
         21:      val = 30'sd29;
         22:      val = 30'sd14;
         23:      val = 30'sd7;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/pt2_req_if.sv =====
interface pt2_req_if;
   logic                                valid;
   logic                                ready;
   logic [pt2_pkg::OP_W-1:0]            req_type;
   logic signed [pt2_pkg::COORD_W-1:0]  px;
   logic signed [pt2_pkg::COORD_W-1:0]  py;
   logic signed [pt2_pkg::COORD_W-1:0]  cx;
   logic signed [pt2_pkg::COORD_W-1:0]  cy;
   logic signed [pt2_pkg::ANGLE_W-1:0]  angle_deg;
   logic signed [pt2_pkg::FACTOR_W-1:0] factor;
   logic signed [pt2_pkg::COORD_W-1:0]  dx;
   logic signed [pt2_pkg::COORD_W-1:0]  dy;

   modport source (output valid, req_type, px, py, cx, cy, angle_deg, factor, dx, dy,
                   input ready);
   modport sink   (input valid, req_type, px, py, cx, cy, angle_deg, factor, dx, dy,
                   output ready);
endinterface

// ===== rtl/pt2_rsp_if.sv =====
interface pt2_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [pt2_pkg::COORD_W-1:0] rx;
   logic signed [pt2_pkg::COORD_W-1:0] ry;
   logic                               clipped;

   modport source (output valid, rx, ry, clipped, input ready);
   modport sink   (input valid, rx, ry, clipped, output ready);
endinterface

// ===== rtl/pt2_prep.sv =====
module pt2_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  pt2_pkg::req_item_type up_data,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output pt2_pkg::cord_type     dn_data
);

   logic                         valid_ff;
   pt2_pkg::cord_type            data_ff;
   pt2_pkg::cord_type            data_in;
   logic signed [pt2_pkg::ANG_W-1:0] ang;
   logic signed [pt2_pkg::ANG_W-1:0] ang_red;
   logic signed [pt2_pkg::ANG_W-1:0] ang_fold;
   logic                         fold_neg;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   // reduce the angle into one turn, then fold into a quarter turn either side
   always_comb begin
      ang = pt2_pkg::ANG_W'(up_data.angle_deg);
      if (ang > pt2_pkg::HALF_TURN) begin
         ang_red = ang - pt2_pkg::TURN;
      end else if (ang <= pt2_pkg::NEG_HALF) begin
         ang_red = ang + pt2_pkg::TURN;
      end else begin
         ang_red = ang;
      end
      fold_neg = 1'b0;
      if (ang_red > pt2_pkg::QUARTER_TURN) begin
         ang_fold = ang_red - pt2_pkg::HALF_TURN;
         fold_neg = 1'b1;
      end else if (ang_red < pt2_pkg::NEG_QUARTER) begin
         ang_fold = ang_red + pt2_pkg::HALF_TURN;
         fold_neg = 1'b1;
      end else begin
         ang_fold = ang_red;
      end
   end

   // form offsets from the center, the simple results and the CORDIC seed
   always_comb begin
      data_in.op     = up_data.req_type;
      data_in.neg    = fold_neg;
      data_in.cx     = up_data.cx;
      data_in.cy     = up_data.cy;
      data_in.factor = up_data.factor;
      data_in.u      = pt2_pkg::DIFF_W'(up_data.px) - pt2_pkg::DIFF_W'(up_data.cx);
      data_in.v      = pt2_pkg::DIFF_W'(up_data.py) - pt2_pkg::DIFF_W'(up_data.cy);
      data_in.x      = pt2_pkg::CORDIC_GAIN;
      data_in.y      = '0;
      data_in.z      = pt2_pkg::Z_W'(ang_fold) <<< pt2_pkg::Z_SHIFT;
      data_in.pre_x  = pt2_pkg::PRE_W'(up_data.px);
      data_in.pre_y  = pt2_pkg::PRE_W'(up_data.py);
      case (up_data.req_type)
         pt2_pkg::OP_TRANSLATE: begin
            data_in.pre_x = pt2_pkg::PRE_W'(up_data.px) + pt2_pkg::PRE_W'(up_data.dx);
            data_in.pre_y = pt2_pkg::PRE_W'(up_data.py) + pt2_pkg::PRE_W'(up_data.dy);
         end
         pt2_pkg::OP_MIRROR_X: begin
            data_in.pre_y = (pt2_pkg::PRE_W'(up_data.cy) <<< 1) - pt2_pkg::PRE_W'(up_data.py);
         end
         pt2_pkg::OP_MIRROR_Y: begin
            data_in.pre_x = (pt2_pkg::PRE_W'(up_data.cx) <<< 1) - pt2_pkg::PRE_W'(up_data.px);
         end
         default: begin
            data_in.pre_x = pt2_pkg::PRE_W'(up_data.px);
         end
      endcase
   end

   // advance when the next stage takes the held request
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/pt2_cordic_cell.sv =====
module pt2_cordic_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [pt2_pkg::IDX_W-1:0] stage_idx,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  pt2_pkg::cord_type         up_data,
   output logic                      dn_valid,
   input  logic                      dn_ready,
   output pt2_pkg::cord_type         dn_data
);

   logic                              valid_ff;
   pt2_pkg::cord_type                 data_ff;
   pt2_pkg::cord_type                 data_in;
   logic signed [pt2_pkg::XY_W-1:0]   x_sh;
   logic signed [pt2_pkg::XY_W-1:0]   y_sh;
   logic signed [pt2_pkg::Z_W-1:0]    atan;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   // one micro-rotation toward zero residual angle
   always_comb begin
      x_sh    = up_data.x >>> stage_idx;
      y_sh    = up_data.y >>> stage_idx;
      atan    = pt2_pkg::arctan_of(stage_idx);
      data_in = up_data;
      if (!up_data.z[pt2_pkg::Z_W-1]) begin
         data_in.x = up_data.x - y_sh;
         data_in.y = up_data.y + x_sh;
         data_in.z = up_data.z - atan;
      end else begin
         data_in.x = up_data.x + y_sh;
         data_in.y = up_data.y - x_sh;
         data_in.z = up_data.z + atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/pt2_product.sv =====
module pt2_product (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  pt2_pkg::cord_type up_data,
   output logic              dn_valid,
   input  logic              dn_ready,
   output pt2_pkg::prod_type dn_data
);

   logic              valid_ff;
   pt2_pkg::prod_type data_ff;
   pt2_pkg::prod_type data_in;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   // multiply the center offsets by cosine, sine and the scale factor
   always_comb begin
      data_in.op    = up_data.op;
      data_in.neg   = up_data.neg;
      data_in.pre_x = up_data.pre_x;
      data_in.pre_y = up_data.pre_y;
      data_in.cx    = up_data.cx;
      data_in.cy    = up_data.cy;
      data_in.ux    = pt2_pkg::PROD_W'(up_data.u) * pt2_pkg::PROD_W'(up_data.x);
      data_in.vy    = pt2_pkg::PROD_W'(up_data.v) * pt2_pkg::PROD_W'(up_data.y);
      data_in.uy    = pt2_pkg::PROD_W'(up_data.u) * pt2_pkg::PROD_W'(up_data.y);
      data_in.vx    = pt2_pkg::PROD_W'(up_data.v) * pt2_pkg::PROD_W'(up_data.x);
      data_in.us    = pt2_pkg::SPROD_W'(up_data.u) * pt2_pkg::SPROD_W'(up_data.factor);
      data_in.vs    = pt2_pkg::SPROD_W'(up_data.v) * pt2_pkg::SPROD_W'(up_data.factor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/pt2_finish.sv =====
module pt2_finish (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  pt2_pkg::prod_type up_data,
   output logic              dn_valid,
   input  logic              dn_ready,
   output pt2_pkg::res_type  dn_data
);

   localparam logic signed [pt2_pkg::WIDE_W-1:0] ROUND_T =
      pt2_pkg::WIDE_W'(1) <<< (pt2_pkg::TRIG_FRAC - 1);
   localparam logic signed [pt2_pkg::WIDE_W-1:0] ROUND_F =
      (pt2_pkg::WIDE_W'(1) <<< pt2_pkg::FRAC_BITS) >>> 1;

   logic                                 valid_ff;
   pt2_pkg::res_type                     res_ff;
   pt2_pkg::res_type                     res_in;
   logic signed [pt2_pkg::WIDE_W-1:0]    sum_x;
   logic signed [pt2_pkg::WIDE_W-1:0]    sum_y;
   logic signed [pt2_pkg::WIDE_W-1:0]    rot_x;
   logic signed [pt2_pkg::WIDE_W-1:0]    rot_y;
   logic signed [pt2_pkg::WIDE_W-1:0]    scl_x;
   logic signed [pt2_pkg::WIDE_W-1:0]    scl_y;
   logic signed [pt2_pkg::WIDE_W-1:0]    wide_x;
   logic signed [pt2_pkg::WIDE_W-1:0]    wide_y;
   logic                                 clip_x;
   logic                                 clip_y;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = res_ff;

   // round the rotated and scaled offsets and add the center back
   always_comb begin
      sum_x = pt2_pkg::WIDE_W'(up_data.ux) - pt2_pkg::WIDE_W'(up_data.vy);
      sum_y = pt2_pkg::WIDE_W'(up_data.uy) + pt2_pkg::WIDE_W'(up_data.vx);
      if (up_data.neg) begin
         sum_x = -sum_x;
         sum_y = -sum_y;
      end
      rot_x = ((sum_x + ROUND_T) >>> pt2_pkg::TRIG_FRAC) + pt2_pkg::WIDE_W'(up_data.cx);
      rot_y = ((sum_y + ROUND_T) >>> pt2_pkg::TRIG_FRAC) + pt2_pkg::WIDE_W'(up_data.cy);
      scl_x = ((pt2_pkg::WIDE_W'(up_data.us) + ROUND_F) >>> pt2_pkg::FRAC_BITS)
              + pt2_pkg::WIDE_W'(up_data.cx);
      scl_y = ((pt2_pkg::WIDE_W'(up_data.vs) + ROUND_F) >>> pt2_pkg::FRAC_BITS)
              + pt2_pkg::WIDE_W'(up_data.cy);
   end

   // pick the result for the operation and saturate it
   always_comb begin
      case (up_data.op)
         pt2_pkg::OP_SCALE: begin
            wide_x = scl_x;
            wide_y = scl_y;
         end
         pt2_pkg::OP_ROTATE: begin
            wide_x = rot_x;
            wide_y = rot_y;
         end
         default: begin
            wide_x = pt2_pkg::WIDE_W'(up_data.pre_x);
            wide_y = pt2_pkg::WIDE_W'(up_data.pre_y);
         end
      endcase
      clip_x = 1'b1;
      clip_y = 1'b1;
      if (wide_x > pt2_pkg::COORD_MAX) begin
         res_in.rx = pt2_pkg::COORD_W'(pt2_pkg::COORD_MAX);
      end else if (wide_x < pt2_pkg::COORD_MIN) begin
         res_in.rx = pt2_pkg::COORD_W'(pt2_pkg::COORD_MIN);
      end else begin
         res_in.rx = pt2_pkg::COORD_W'(wide_x);
         clip_x    = 1'b0;
      end
      if (wide_y > pt2_pkg::COORD_MAX) begin
         res_in.ry = pt2_pkg::COORD_W'(pt2_pkg::COORD_MAX);
      end else if (wide_y < pt2_pkg::COORD_MIN) begin
         res_in.ry = pt2_pkg::COORD_W'(pt2_pkg::COORD_MIN);
      end else begin
         res_in.ry = pt2_pkg::COORD_W'(wide_y);
         clip_y    = 1'b0;
      end
      res_in.clipped = clip_x || clip_y;
   end

   // hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         res_ff <= res_in;
      end
   end

endmodule

// ===== rtl/point_transform_2d.sv =====
// point_transform_2d: one planar transform of a point per request.
// req_chan carries the operation code, the point, the center, the angle,
// the scale factor and the offsets; rsp_chan returns the transformed point
// and a flag that is set when either coordinate saturated.
// Operations: translate, scale about the center, counterclockwise rotate about
// the center, mirror across the horizontal or vertical line through the center.
// Unused codes pass the point through.
// Throughput: one request per cycle while the receiver takes responses.
// Every pipeline register moves on its own ready, so one CORDIC iteration
// is done per cell and per clock, and the products take one register stage
// ahead of the output register.
// When the receiver stalls, the response holds in the output register and
// the pipeline keeps filling its empty stages; req_chan.ready drops only
// once every stage holds a request.
// Reset (synchronous, active high) empties the pipeline; no response is
// valid in the cycle after it.
module point_transform_2d (
   input  logic        clock,
   input  logic        reset,
   pt2_req_if.sink     req_chan,
   pt2_rsp_if.source   rsp_chan
);

   pt2_pkg::req_item_type                req_data;
   pt2_pkg::cord_type                    cell_data [0:pt2_pkg::CORDIC_STAGES];
   logic [pt2_pkg::CORDIC_STAGES:0]      cell_valid;
   logic [pt2_pkg::CORDIC_STAGES:0]      cell_ready;
   pt2_pkg::prod_type                    prod_data;
   logic                                 prod_valid;
   logic                                 prod_ready;
   pt2_pkg::res_type                     res_data;

   // gather the request fields
   always_comb begin
      req_data.req_type  = req_chan.req_type;
      req_data.px        = req_chan.px;
      req_data.py        = req_chan.py;
      req_data.cx        = req_chan.cx;
      req_data.cy        = req_chan.cy;
      req_data.angle_deg = req_chan.angle_deg;
      req_data.factor    = req_chan.factor;
      req_data.dx        = req_chan.dx;
      req_data.dy        = req_chan.dy;
   end

   pt2_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_chan.valid),
      .up_ready (req_chan.ready),
      .up_data  (req_data),
      .dn_valid (cell_valid[0]),
      .dn_ready (cell_ready[0]),
      .dn_data  (cell_data[0])
   );

   // chain of CORDIC cells, one iteration each
   for (genvar i = 0; i < pt2_pkg::CORDIC_STAGES; i++) begin : g_cell
      pt2_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (pt2_pkg::IDX_W'(i)),
         .up_valid  (cell_valid[i]),
         .up_ready  (cell_ready[i]),
         .up_data   (cell_data[i]),
         .dn_valid  (cell_valid[i+1]),
         .dn_ready  (cell_ready[i+1]),
         .dn_data   (cell_data[i+1])
      );
   end

   pt2_product u_product (
      .clock    (clock),
      .reset    (reset),
      .up_valid (cell_valid[pt2_pkg::CORDIC_STAGES]),
      .up_ready (cell_ready[pt2_pkg::CORDIC_STAGES]),
      .up_data  (cell_data[pt2_pkg::CORDIC_STAGES]),
      .dn_valid (prod_valid),
      .dn_ready (prod_ready),
      .dn_data  (prod_data)
   );

   pt2_finish u_finish (
      .clock    (clock),
      .reset    (reset),
      .up_valid (prod_valid),
      .up_ready (prod_ready),
      .up_data  (prod_data),
      .dn_valid (rsp_chan.valid),
      .dn_ready (rsp_chan.ready),
      .dn_data  (res_data)
   );

   assign rsp_chan.rx      = res_data.rx;
   assign rsp_chan.ry      = res_data.ry;
   assign rsp_chan.clipped = res_data.clipped;

endmodule

// ===== rtl/pt2_checker.sv =====
module pt2_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [pt2_pkg::COORD_W-1:0] rx,
   input logic signed [pt2_pkg::COORD_W-1:0] ry,
   input logic                               clipped
);

   localparam logic signed [pt2_pkg::COORD_W-1:0] C_MAX =
      pt2_pkg::COORD_W'(pt2_pkg::COORD_MAX);
   localparam logic signed [pt2_pkg::COORD_W-1:0] C_MIN =
      pt2_pkg::COORD_W'(pt2_pkg::COORD_MIN);

   logic [pt2_pkg::CNT_W-1:0] count_ff;
   logic [pt2_pkg::CNT_W-1:0] count_in;

   // track requests in flight
   always_comb begin
      count_in = count_ff;
      if (req_valid && req_ready && !(rsp_valid && rsp_ready)) begin
         count_in = count_ff + 1'b1;
      end else if (!(req_valid && req_ready) && rsp_valid && rsp_ready) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rx) && $stable(ry) && $stable(clipped))
      else $error("stalled response changed");

   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && clipped |-> rx == C_MAX || rx == C_MIN || ry == C_MAX || ry == C_MIN)
      else $error("clipped set on an unsaturated result");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> !rsp_valid)
      else $error("response without a request in flight");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pt2_pkg::CNT_W'(pt2_pkg::PIPE_DEPTH))
      else $error("more requests in flight than pipeline stages");

endmodule

bind point_transform_2d pt2_checker u_pt2_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rx        (rsp_chan.rx),
   .ry        (rsp_chan.ry),
   .clipped   (rsp_chan.clipped)
);

// ===== verif/point_transform_2d_tb.sv =====
module point_transform_2d_tb;
   import pt2_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 4;
   localparam int CYCLE_LIMIT    = 600000;
   localparam int HOLDOFF_CYCLES = 160;
   localparam int SETTLE_CYCLES  = PIPE_DEPTH + 8;

   localparam int COORD_TOP     = (1 << (COORD_W - 1)) - 1;
   localparam int COORD_BOTTOM  = -(1 << (COORD_W - 1));
   localparam int FACTOR_TOP    = (1 << (FACTOR_W - 1)) - 1;
   localparam int FACTOR_BOTTOM = -(1 << (FACTOR_W - 1));
   localparam int ONE           = 1 << FRAC_BITS;
   localparam int FULL_TURN     = TURN;
   localparam int HALF          = HALF_TURN;
   localparam int QUARTER       = QUARTER_TURN;

   localparam longint SCALE_HALF = longint'(1) << (FRAC_BITS - 1);
   localparam longint TRIG_HALF  = longint'(1) << (TRIG_FRAC - 1);

   // codes past the last defined operation pass the point through
   localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_MIRROR_Y + 1'b1;
   localparam logic [OP_W-1:0] OP_LAST_UNUSED  = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pt2_req_if req_bus ();
   pt2_rsp_if rsp_bus ();

   point_transform_2d dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // arctangent of 2^-i in 2^-20 degree units
   longint arctan_steps [24] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7
   };

   res_type expected_points [$];
   int      mismatch_count = 0;
   int      cycle_count    = 0;
   bit      sender_idles   = 1'b0;
   bit      receiver_idles = 1'b0;
   bit      holdoff_request = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // rotate the unit vector by the angle; fold into +-90 degrees first
   function automatic void cordic_sin_cos(input longint ang, output longint cos_v,
                                          output longint sin_v);
      longint r, x, y, z, xs, ys;
      logic   flip;
      int     i;
      r = ang % longint'(FULL_TURN);
      if (r < 0) r += FULL_TURN;
      if (r > HALF) r -= FULL_TURN;
      flip = 1'b0;
      if (r > QUARTER) begin
         r -= HALF;
         flip = 1'b1;
      end else if (r < -QUARTER) begin
         r += HALF;
         flip = 1'b1;
      end
      x = CORDIC_GAIN;
      y = 0;
      z = r <<< Z_SHIFT;
      for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - arctan_steps[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + arctan_steps[i];
         end
      end
      cos_v = flip ? -x : x;
      sin_v = flip ? -y : y;
   endfunction

   function automatic logic signed [COORD_W-1:0] saturate_coord(input longint val,
                                                               output logic hit);
      hit = 1'b1;
      if (val > COORD_TOP) return COORD_W'(COORD_TOP);
      if (val < COORD_BOTTOM) return COORD_W'(COORD_BOTTOM);
      hit = 1'b0;
      return COORD_W'(val);
   endfunction

   function automatic res_type predict_transform(input req_item_type item);
      longint  px, py, cx, cy, dx, dy, fac, ang, nx, ny, cos_v, sin_v;
      logic    x_hit, y_hit;
      res_type res;
      px  = $signed(item.px);
      py  = $signed(item.py);
      cx  = $signed(item.cx);
      cy  = $signed(item.cy);
      dx  = $signed(item.dx);
      dy  = $signed(item.dy);
      fac = $signed(item.factor);
      ang = $signed(item.angle_deg);
      nx  = px;
      ny  = py;
      case (item.req_type)
         OP_TRANSLATE: begin
            nx = px + dx;
            ny = py + dy;
         end
         OP_SCALE: begin
            nx = cx + (((px - cx) * fac + SCALE_HALF) >>> FRAC_BITS);
            ny = cy + (((py - cy) * fac + SCALE_HALF) >>> FRAC_BITS);
         end
         OP_ROTATE: begin
            cordic_sin_cos(ang, cos_v, sin_v);
            nx = cx + (((px - cx) * cos_v - (py - cy) * sin_v + TRIG_HALF) >>> TRIG_FRAC);
            ny = cy + (((px - cx) * sin_v + (py - cy) * cos_v + TRIG_HALF) >>> TRIG_FRAC);
         end
         OP_MIRROR_X: ny = 2 * cy - py;
         OP_MIRROR_Y: nx = 2 * cx - px;
         default: ;
      endcase
      res.rx      = saturate_coord(nx, x_hit);
      res.ry      = saturate_coord(ny, y_hit);
      res.clipped = x_hit | y_hit;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // mostly short gaps, now and then a long one
   function automatic int gap_cycles();
      if ($urandom_range(0, 9) == 0) return $urandom_range(12, 48);
      return $urandom_range(1, 3);
   endfunction

   function automatic req_item_type make_request(input logic [OP_W-1:0] op,
                                                 input int px, input int py,
                                                 input int cx, input int cy,
                                                 input int ang, input int fac,
                                                 input int dx, input int dy);
      req_item_type item;
      item.req_type  = op;
      item.px        = COORD_W'(px);
      item.py        = COORD_W'(py);
      item.cx        = COORD_W'(cx);
      item.cy        = COORD_W'(cy);
      item.angle_deg = ANGLE_W'(ang);
      item.factor    = FACTOR_W'(fac);
      item.dx        = COORD_W'(dx);
      item.dy        = COORD_W'(dy);
      return item;
   endfunction

   function automatic int random_coord();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return COORD_TOP;
               1:       return COORD_BOTTOM;
               2:       return 0;
               default: return -1;
            endcase
         end
         1, 2, 3: return int'($signed(COORD_W'($urandom)));
         default: return int'($urandom_range(0, 131071)) - 65536;
      endcase
   endfunction

   function automatic int random_angle();
      int ang;
      if ($urandom_range(0, 3) == 0) begin
         // land on or next to a quadrant boundary
         ang = QUARTER * (int'($urandom_range(0, 8)) - 4) + int'($urandom_range(0, 2)) - 1;
         if (ang > FULL_TURN) ang = FULL_TURN;
         if (ang < -FULL_TURN) ang = -FULL_TURN;
         return ang;
      end
      return int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN;
   endfunction

   function automatic int random_factor();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return FACTOR_TOP;
               1:       return FACTOR_BOTTOM;
               2:       return 0;
               default: return ONE;
            endcase
         end
         1, 2, 3, 4: return int'($signed(FACTOR_W'($urandom)));
         default: return int'($urandom_range(0, 1023)) - 512;
      endcase
   endfunction

   function automatic req_item_type random_request();
      logic [OP_W-1:0] op;
      case ($urandom_range(0, 20))
         0, 1, 2, 3:     op = OP_TRANSLATE;
         4, 5, 6, 7:     op = OP_SCALE;
         8, 9, 10, 11:   op = OP_ROTATE;
         12, 13, 14, 15: op = OP_MIRROR_X;
         16, 17, 18, 19: op = OP_MIRROR_Y;
         default:        op = OP_FIRST_UNUSED + OP_W'($urandom_range(0, 2));
      endcase
      return make_request(op, random_coord(), random_coord(), random_coord(),
                          random_coord(), random_angle(), random_factor(),
                          random_coord(), random_coord());
   endfunction

   // offer one request, hold it until accepted, then record its result
   task automatic send_request(input req_item_type item);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap_cycles()) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= item.req_type;
      req_bus.px        <= item.px;
      req_bus.py        <= item.py;
      req_bus.cx        <= item.cx;
      req_bus.cy        <= item.cy;
      req_bus.angle_deg <= item.angle_deg;
      req_bus.factor    <= item.factor;
      req_bus.dx        <= item.dx;
      req_bus.dy        <= item.dy;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_points.push_back(predict_transform(item));
   endtask

   // drop valid and hold until every outstanding request has answered
   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_translate_mirror();
      send_request(make_request(OP_TRANSLATE, 1000, -2000, 0, 0, 0, 0, ONE, -2 * ONE));
      send_request(make_request(OP_TRANSLATE, COORD_TOP, COORD_BOTTOM, 0, 0, 0, 0,
                                COORD_TOP, COORD_BOTTOM));
      send_request(make_request(OP_TRANSLATE, COORD_BOTTOM, COORD_TOP, COORD_TOP,
                                COORD_BOTTOM, 0, 0, COORD_TOP, COORD_BOTTOM));
      send_request(make_request(OP_MIRROR_X, 77, COORD_BOTTOM, COORD_BOTTOM, COORD_TOP,
                                0, 0, 0, 0));
      send_request(make_request(OP_MIRROR_Y, COORD_TOP, -5, COORD_BOTTOM, COORD_TOP,
                                0, 0, 0, 0));
      send_request(make_request(OP_MIRROR_X, 300, 300, -100, -100, 0, 0, 0, 0));
   endtask

   task automatic test_unused_codes();
      send_request(make_request(OP_FIRST_UNUSED, COORD_TOP, COORD_BOTTOM, COORD_TOP,
                                COORD_BOTTOM, FULL_TURN, FACTOR_TOP, COORD_TOP, COORD_TOP));
      send_request(make_request(OP_FIRST_UNUSED + 1'b1, COORD_BOTTOM, COORD_TOP,
                                COORD_BOTTOM, COORD_TOP, -FULL_TURN, FACTOR_BOTTOM,
                                COORD_BOTTOM, COORD_BOTTOM));
      send_request(make_request(OP_LAST_UNUSED, -1, 0, -1, 0, -1, -1, -1, 0));
   endtask

   task automatic test_scale();
      send_request(make_request(OP_SCALE, 5000, -7000, 1000, 2000, 0, ONE, 0, 0));
      send_request(make_request(OP_SCALE, COORD_TOP, COORD_BOTTOM, 123, -456, 0, 0, 0, 0));
      send_request(make_request(OP_SCALE, COORD_TOP, COORD_BOTTOM, COORD_BOTTOM, COORD_TOP,
                                0, FACTOR_TOP, 0, 0));
      send_request(make_request(OP_SCALE, COORD_TOP, COORD_BOTTOM, 0, 0, 0, FACTOR_BOTTOM,
                                0, 0));
      // half-way products round up on both signs
      send_request(make_request(OP_SCALE, 11, 9, 10, 10, 0, ONE / 2, 0, 0));
      send_request(make_request(OP_SCALE, -3000, 4500, 250, -250, 0, -3 * ONE / 2, 0, 0));
   endtask

   task automatic test_rotate();
      int angles [9] = '{0, QUARTER, HALF, -HALF, FULL_TURN, -FULL_TURN, 12800, -12800, 1};
      foreach (angles[k])
         send_request(make_request(OP_ROTATE, 2560, -1280, 256, 512, angles[k], 0, 0, 0));
      // 45 degrees on a far corner runs off the range
      send_request(make_request(OP_ROTATE, COORD_TOP, COORD_TOP, COORD_BOTTOM, COORD_BOTTOM,
                                QUARTER / 2, 0, 0, 0));
   endtask

   task automatic test_random_traffic(input int count, input bit src_gaps,
                                      input bit dst_stalls);
      sender_idles   = src_gaps;
      receiver_idles = dst_stalls;
      repeat (count) send_request(random_request());
   endtask

   // stall the output long enough that the pipeline fills and blocks its input
   task automatic test_output_holdoff(input int count);
      sender_idles    = 1'b0;
      receiver_idles  = 1'b0;
      holdoff_request = 1'b1;
      repeat (count) send_request(random_request());
   endtask

   task automatic test_drain_pause(input int count);
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      repeat (count / 2) send_request(random_request());
      pause_until_drained();
      repeat (count - count / 2) send_request(random_request());
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.req_type  = OP_TRANSLATE;
      req_bus.px        = '0;
      req_bus.py        = '0;
      req_bus.cx        = '0;
      req_bus.cy        = '0;
      req_bus.angle_deg = '0;
      req_bus.factor    = '0;
      req_bus.dx        = '0;
      req_bus.dy        = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_translate_mirror();
      test_unused_codes();
      test_scale();
      test_rotate();
      test_random_traffic(250, 1'b0, 1'b0);
      test_random_traffic(200, 1'b1, 1'b0);
      test_random_traffic(200, 1'b0, 1'b1);
      test_random_traffic(300, 1'b1, 1'b1);
      test_output_holdoff(80);
      test_drain_pause(100);

      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_points.size() == 0)
         $display("point_transform_2d: match");
      else
         $display("point_transform_2d: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   initial begin : rsp_ready_driver
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            holdoff_request = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap_cycles()) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input longint want, input longint got,
                              input logic known);
      if (!known || want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // compare each accepted response with the oldest outstanding request
   always @(posedge clock) begin : response_check
      res_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_points.size() == 0) begin
            mismatch_count++;
            $display("%0t: response with no request outstanding, expected none, got rx %0d",
                     $time, $signed(rsp_bus.rx));
         end else begin
            want = expected_points.pop_front();
            check_field("rx", $signed(want.rx), $signed(rsp_bus.rx), !$isunknown(rsp_bus.rx));
            check_field("ry", $signed(want.ry), $signed(rsp_bus.ry), !$isunknown(rsp_bus.ry));
            check_field("clipped", longint'(want.clipped), longint'(rsp_bus.clipped),
                        !$isunknown(rsp_bus.clipped));
         end
      end
   end

   // give up on a hung pipeline
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("point_transform_2d: mismatch");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
rtl/pt2_pkg.sv
rtl/pt2_req_if.sv
rtl/pt2_rsp_if.sv
rtl/pt2_prep.sv
rtl/pt2_cordic_cell.sv
rtl/pt2_product.sv
rtl/pt2_finish.sv
rtl/point_transform_2d.sv
rtl/pt2_checker.sv
verif/point_transform_2d_tb.sv
